[rtl/elh_pkg.sv]
// shared types and constants for the edge length histogram
package elh_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] CSR_MAX_DISTANCE = 2'd0;
   localparam logic [1:0] CSR_BUCKET_COUNT = 2'd1;
   localparam logic [1:0] CSR_LOG_SCALE    = 2'd2;

   // register reset values
   localparam logic [32:0] MAX_DISTANCE_RESET = 33'd40075100;
   localparam logic [7:0]  BUCKET_COUNT_RESET = 8'd100;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // fixed field widths
   localparam int DIST_W = 33;
   localparam int LOG_W  = 22;

   typedef struct packed {
      logic               opcode;
      logic [31:0]        source_id;
      logic [31:0]        target_id;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic [6:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [6:0]  bucket_index;
      logic [31:0] bucket_count_value;
      logic [32:0] longest_seen;
      logic        skipped;
   } rsp_type;

endpackage

[rtl/elh_ram.sv]
// generic single port write, single port read ram with registered read
module elh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= storage_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/elh_sqrt.sv]
// iterative floor square root, two radicand bits per cycle
module elh_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [66:0] radicand,
   output logic        done,
   output logic [32:0] root
);

   logic [67:0] rad_ff, rad_in;
   logic [36:0] rem_ff, rem_in;
   logic [33:0] root_ff, root_in;
   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [36:0] rem_sh;
   logic [36:0] trial;

   // one restoring step per cycle
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[34:0], rad_ff[67:66]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         rad_in  = {1'b0, radicand};
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[65:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[32:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[32:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd33) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = root_ff[32:0];

endmodule

[rtl/elh_log2.sv]
// iterative q16 log2: normalize one bit per cycle, then sixteen squarings
module elh_log2 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [33:0] x,
   output logic        done,
   output logic [21:0] result
);

   typedef enum logic [2:0] {
      L_IDLE   = 3'b001,
      L_NORM   = 3'b010,
      L_SQUARE = 3'b100
   } log_state_type;

   log_state_type state_ff, state_in;
   logic [33:0] norm_ff, norm_in;
   logic [31:0] mant_ff, mant_in;
   logic [5:0]  exp_ff, exp_in;
   logic [15:0] frac_ff, frac_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [63:0] prod;
   logic [32:0] prod_sh;

   assign prod    = mant_ff * mant_ff;
   assign prod_sh = prod[63:31];

   // normalize, then square and collect one fraction bit per cycle
   always_comb begin
      state_in = state_ff;
      norm_in  = norm_ff;
      mant_in  = mant_ff;
      exp_in   = exp_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               norm_in = x;
               exp_in  = 6'd33;
               frac_in = '0;
               cnt_in  = '0;
               if (x == '0) begin
                  exp_in  = '0;
                  done_in = 1'b1;
               end else begin
                  state_in = L_NORM;
               end
            end
         end
         L_NORM: begin
            if (norm_ff[33]) begin
               mant_in  = norm_ff[33:2];
               state_in = L_SQUARE;
            end else begin
               norm_in = {norm_ff[32:0], 1'b0};
               exp_in  = exp_ff - 6'd1;
            end
         end
         L_SQUARE: begin
            if (prod_sh[32]) begin
               mant_in = prod_sh[32:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               mant_in = prod_sh[31:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      norm_ff <= norm_in;
      mant_ff <= mant_in;
      exp_ff  <= exp_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = {exp_ff, frac_ff};

endmodule

[rtl/elh_div.sv]
// restoring divider, one quotient bit per cycle
module elh_div #(
   parameter int NW = 41
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [32:0]   divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int SW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [32:0]   den_ff, den_in;
   logic [32:0]   rem_ff, rem_in;
   logic [SW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [33:0]   rem_sh;
   logic [33:0]   rem_sub;

   assign rem_sh  = {rem_ff, num_ff[NW-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   // shift in a dividend bit, subtract when it fits
   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         quo_in  = '0;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[32:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[32:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/edge_length_histogram.sv]
// edge length histogram: distance, bucketing, counter memory update
// A read goes through fetch, update and output; a skipped add goes straight to
// output; an add squares, sums and takes the square root, then in log mode runs log2
// twice, then divides in the NW-bit divider (NW = 33+clog2(MAX_BUCKETS+1)) unless the
// divisor is zero. One word is in work at a time; the next is taken in the cycle after
// its result is loaded. Reset: synchronous; a clearing pass over all MAX_BUCKETS
// entries zeroes the counter memory, no request word is taken during it.
module edge_length_histogram #(
   parameter int MAX_BUCKETS = 128,
   parameter int COUNT_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  elh_pkg::req_type req_word,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output elh_pkg::rsp_type rsp_word,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [32:0]     csr_write_data
);

   import elh_pkg::*;

   localparam int AW = $clog2(MAX_BUCKETS);
   localparam int CW = $clog2(MAX_BUCKETS + 1);
   localparam int NW = DIST_W + CW;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_SQUARE = 11'b00000000100,
      S_SUM    = 11'b00000001000,
      S_ROOT   = 11'b00000010000,
      S_LOGM   = 11'b00000100000,
      S_LOGD   = 11'b00001000000,
      S_DIVIDE = 11'b00010000000,
      S_FETCH  = 11'b00100000000,
      S_UPDATE = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [32:0]            max_ff, max_in;
   logic [7:0]             cnt_cfg_ff, cnt_cfg_in;
   logic                   log_ff, log_in;
   logic [32:0]            dx_ff, dx_in, dy_ff, dy_in;
   logic [65:0]            sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [32:0]            dist_ff, dist_in;
   logic [32:0]            longest_ff, longest_in;
   logic [LOG_W-1:0]       lm_ff, lm_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [6:0]             idx_ff, idx_in;
   logic                   is_read_ff, is_read_in;
   logic                   in_range_ff, in_range_in;
   logic                   skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0] value_ff, value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_word_ff, rsp_word_in;

   logic [CW-1:0]          count_use;
   logic [AW-1:0]          count_top;
   logic signed [32:0]     diff_x, diff_y;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [COUNT_WIDTH-1:0] mem_wr_data, mem_rd_data;
   logic                   sqrt_start, sqrt_done;
   logic [32:0]            sqrt_root;
   logic                   log_start, log_done;
   logic [33:0]            log_x;
   logic [LOG_W-1:0]       log_res;
   logic                   div_start, div_done;
   logic [NW-1:0]          div_num, div_q;
   logic [32:0]            div_den;

   // bucket count clamped into 1..MAX_BUCKETS
   always_comb begin
      if (cnt_cfg_ff == '0) begin
         count_use = CW'(1);
      end else if (32'(cnt_cfg_ff) > 32'(MAX_BUCKETS)) begin
         count_use = CW'(MAX_BUCKETS);
      end else begin
         count_use = CW'(cnt_cfg_ff);
      end
   end
   assign count_top = AW'(count_use - CW'(1));

   // coordinate differences
   assign diff_x = 33'(req_word.first_x) - 33'(req_word.second_x);
   assign diff_y = 33'(req_word.first_y) - 33'(req_word.second_y);

   // unit starts and operand selection
   assign sqrt_start = (state_ff == S_SUM);
   assign log_start  = ((state_ff == S_ROOT) && sqrt_done && log_ff) ||
                       ((state_ff == S_LOGM) && log_done);
   assign log_x      = (state_ff == S_ROOT) ? {1'b0, max_ff} : ({1'b0, dist_ff} + 34'd1);
   assign div_start  = ((state_ff == S_ROOT) && sqrt_done && !log_ff && (max_ff != '0)) ||
                       ((state_ff == S_LOGD) && log_done && (lm_ff != '0));
   assign div_num    = (state_ff == S_ROOT) ? NW'(sqrt_root) * NW'(count_use)
                                            : NW'(log_res) * NW'(count_use);
   assign div_den    = (state_ff == S_ROOT) ? max_ff : 33'(lm_ff);

   // counter memory write port
   assign mem_wr_en   = (state_ff == S_CLEAR) || ((state_ff == S_UPDATE) && !is_read_ff);
   assign mem_wr_addr = (state_ff == S_CLEAR) ? clr_cnt_ff : addr_ff;
   assign mem_wr_data = (state_ff == S_CLEAR) ? '0 :
                        ((mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      max_in       = max_ff;
      cnt_cfg_in   = cnt_cfg_ff;
      log_in       = log_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sqa_in       = sqa_ff;
      sqb_in       = sqb_ff;
      dist_in      = dist_ff;
      longest_in   = longest_ff;
      lm_in        = lm_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      is_read_in   = is_read_ff;
      in_range_in  = in_range_ff;
      skip_in      = skip_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      // configuration writes
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_DISTANCE: max_in     = csr_write_data;
            CSR_BUCKET_COUNT: cnt_cfg_in = csr_write_data[7:0];
            CSR_LOG_SCALE:    log_in     = csr_write_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MAX_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               skip_in    = 1'b0;
               is_read_in = 1'b0;
               if (req_word.opcode == OP_READ) begin
                  is_read_in  = 1'b1;
                  addr_in     = AW'(req_word.read_index);
                  idx_in      = req_word.read_index;
                  in_range_in = 32'(req_word.read_index) < 32'(MAX_BUCKETS);
                  state_in    = S_FETCH;
               end else if (req_word.source_id == req_word.target_id) begin
                  skip_in  = 1'b1;
                  idx_in   = '0;
                  value_in = '0;
                  state_in = S_OUT;
               end else begin
                  dx_in    = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
                  dy_in    = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
                  state_in = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            sqa_in   = dx_ff * dx_ff;
            sqb_in   = dy_ff * dy_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               dist_in = sqrt_root;
               if (sqrt_root > longest_ff) begin
                  longest_in = sqrt_root;
               end
               if (log_ff) begin
                  state_in = S_LOGM;
               end else if (max_ff == '0) begin
                  addr_in  = count_top;
                  idx_in   = 7'(count_top);
                  state_in = S_FETCH;
               end else begin
                  state_in = S_DIVIDE;
               end
            end
         end
         S_LOGM: begin
            if (log_done) begin
               lm_in    = log_res;
               state_in = S_LOGD;
            end
         end
         S_LOGD: begin
            if (log_done) begin
               if (lm_ff == '0) begin
                  addr_in  = count_top;
                  idx_in   = 7'(count_top);
                  state_in = S_FETCH;
               end else begin
                  state_in = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               if (div_q >= NW'(count_use)) begin
                  addr_in = count_top;
                  idx_in  = 7'(count_top);
               end else begin
                  addr_in = AW'(div_q);
                  idx_in  = 7'(div_q);
               end
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (is_read_ff) begin
               value_in = in_range_ff ? mem_rd_data : '0;
            end else begin
               value_in = mem_wr_data;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                   = 1'b1;
               rsp_word_in.bucket_index       = idx_ff;
               rsp_word_in.bucket_count_value = 32'(value_ff);
               rsp_word_in.longest_seen       = longest_ff;
               rsp_word_in.skipped            = skip_ff;
               state_in                       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         max_ff       <= MAX_DISTANCE_RESET;
         cnt_cfg_ff   <= BUCKET_COUNT_RESET;
         log_ff       <= 1'b0;
         longest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         max_ff       <= max_in;
         cnt_cfg_ff   <= cnt_cfg_in;
         log_ff       <= log_in;
         longest_ff   <= longest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sqa_ff      <= sqa_in;
      sqb_ff      <= sqb_in;
      dist_ff     <= dist_in;
      lm_ff       <= lm_in;
      addr_ff     <= addr_in;
      idx_ff      <= idx_in;
      is_read_ff  <= is_read_in;
      in_range_ff <= in_range_in;
      skip_ff     <= skip_in;
      value_ff    <= value_in;
      rsp_word_ff <= rsp_word_in;
   end

   // counter memory
   elh_ram #(
      .WIDTH(COUNT_WIDTH),
      .DEPTH(MAX_BUCKETS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   // distance
   elh_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (67'(sqa_ff) + 67'(sqb_ff)),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // log2 shared between the max distance and the sample distance plus one
   elh_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   // bucket divider
   elh_div #(
      .NW(NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // no request taken during the clearing pass
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("request taken during clearing pass");

   // an add always lands inside the buckets in use
   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FETCH) && !is_read_ff) |-> (addr_ff <= count_top))
      else $error("bucket beyond bucket count");

   // longest distance never shrinks
   a_longest_mono: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (longest_ff >= $past(longest_ff)))
      else $error("longest distance decreased");

   // skipped adds report a zero count
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.skipped) |-> (rsp_word_ff.bucket_count_value == '0))
      else $error("skipped word with nonzero count");

endmodule

[sim/edge_length_histogram_checker.sv]
// checker for the edge length histogram: predicts each result word and compares
module edge_length_histogram_checker #(
   parameter int MAX_BUCKETS = 128,
   parameter int COUNT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  elh_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  elh_pkg::rsp_type rsp_word,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [32:0]      csr_write_data,
   output int               errors,
   output int               pending
);
   import elh_pkg::*;

   localparam int FIFO_DEPTH = 16;

   // shadow of the registers and of the block's state
   logic [32:0] range_top;
   logic [7:0]  buckets_cfg;
   logic        log_mode;
   logic [COUNT_WIDTH-1:0] bin_counts [MAX_BUCKETS];
   logic [32:0] longest_dist;

   // expected result words in order
   rsp_type     exp_fifo [FIFO_DEPTH];
   int          fifo_wr;
   int          fifo_rd;
   int          fifo_fill;

   // floor square root of a 66 bit sum of squares
   function automatic logic [32:0] floor_sqrt(logic [65:0] s);
      logic [32:0] r;
      logic [32:0] c;
      logic [67:0] sq;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
         c = r | (33'd1 << b);
         sq = c * c;
         if (sq <= {2'b00, s}) r = c;
      end
      return r;
   endfunction

   // q16 fixed point log2, zero for zero
   function automatic logic [31:0] log2_fixed(logic [63:0] x);
      int          e;
      logic [63:0] m;
      logic [15:0] frac;
      if (x == 0) return 0;
      e = 63;
      while (x[e] == 1'b0) e--;
      m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (e << 16) | frac;
   endfunction

   // absolute difference of two signed coordinates
   function automatic logic [32:0] coord_span(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({a[31], a}) - $signed({b[31], b});
      return (d < 0) ? -d : d;
   endfunction

   // apply one request word to the shadow state and return its result word
   function automatic rsp_type apply_word(req_type w);
      rsp_type     r;
      logic [32:0] dx, dy, span_len;
      logic [65:0] sum_sq;
      logic [63:0] cnt, bucket, lm;
      r = '0;
      if (w.opcode == OP_READ) begin
         r.bucket_index = w.read_index;
         r.bucket_count_value = (w.read_index < MAX_BUCKETS) ?
                                32'(bin_counts[w.read_index]) : 32'd0;
         r.longest_seen = longest_dist;
         return r;
      end
      if (w.source_id == w.target_id) begin
         r.longest_seen = longest_dist;
         r.skipped = 1'b1;
         return r;
      end
      dx = coord_span(w.first_x, w.second_x);
      dy = coord_span(w.first_y, w.second_y);
      sum_sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
      span_len = floor_sqrt(sum_sq);
      if (span_len > longest_dist) longest_dist = span_len;
      cnt = (buckets_cfg == 0) ? 64'd1 : 64'(buckets_cfg);
      if (cnt > 64'(MAX_BUCKETS)) cnt = 64'(MAX_BUCKETS);
      if (!log_mode) begin
         bucket = (range_top == 0) ? cnt - 1 : (64'(span_len) * cnt) / range_top;
      end else begin
         lm = 64'(log2_fixed(64'(range_top)));
         bucket = (lm == 0) ? cnt - 1 : (log2_fixed(64'(span_len) + 1) * cnt) / lm;
      end
      if (bucket >= cnt) bucket = cnt - 1;
      if (bin_counts[bucket] != {COUNT_WIDTH{1'b1}})
         bin_counts[bucket] = bin_counts[bucket] + 1'b1;
      r.bucket_index = bucket[6:0];
      r.bucket_count_value = 32'(bin_counts[bucket]);
      r.longest_seen = longest_dist;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("error at %0t: %s", $realtime, what);
      errors++;
   endtask

   // watch the ports at every rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         range_top = MAX_DISTANCE_RESET;
         buckets_cfg = BUCKET_COUNT_RESET;
         log_mode = 1'b0;
         for (int i = 0; i < MAX_BUCKETS; i++) bin_counts[i] = '0;
         longest_dist = '0;
         fifo_wr = 0;
         fifo_rd = 0;
         fifo_fill = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_MAX_DISTANCE: range_top = csr_write_data;
               CSR_BUCKET_COUNT: buckets_cfg = csr_write_data[7:0];
               CSR_LOG_SCALE:    log_mode = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (fifo_fill == FIFO_DEPTH) begin
               report_mismatch("too many words in flight");
            end else begin
               exp_fifo[fifo_wr] = apply_word(req_word);
               fifo_wr = (fifo_wr + 1) % FIFO_DEPTH;
               fifo_fill++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (fifo_fill == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = exp_fifo[fifo_rd];
               fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
               fifo_fill--;
               if (rsp_word.bucket_index !== want.bucket_index)
                  report_mismatch($sformatf("bucket_index %0d, want %0d",
                                            rsp_word.bucket_index, want.bucket_index));
               if (rsp_word.bucket_count_value !== want.bucket_count_value)
                  report_mismatch($sformatf("bucket_count_value %0d, want %0d",
                                            rsp_word.bucket_count_value,
                                            want.bucket_count_value));
               if (rsp_word.longest_seen !== want.longest_seen)
                  report_mismatch($sformatf("longest_seen %0d, want %0d",
                                            rsp_word.longest_seen, want.longest_seen));
               if (rsp_word.skipped !== want.skipped)
                  report_mismatch($sformatf("skipped %0b, want %0b",
                                            rsp_word.skipped, want.skipped));
            end
         end
      end
      pending = fifo_fill;
   end

endmodule

[sim/edge_length_histogram_tb.sv]
// testbench top for the edge length histogram: stimulus, idling and verdict
module edge_length_histogram_tb;
   import elh_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_word;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [32:0] csr_write_data;
   int          errors;
   int          pending;
   int          send_idle_pct;
   int          recv_stall_pct;

   edge_length_histogram i_dut (.*);

   edge_length_histogram_checker i_checker (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // one request word, with an optional gap in front of it
   task automatic send_word(req_type w);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // drain all results, then let the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [32:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_mode(logic [32:0] top, logic [7:0] cnt, logic lg);
      write_reg(CSR_MAX_DISTANCE, top);
      write_reg(CSR_BUCKET_COUNT, 33'(cnt));
      write_reg(CSR_LOG_SCALE, 33'(lg));
      @(posedge clock);
   endtask

   function automatic req_type add_word(logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] bx, logic [31:0] by);
      req_type w;
      w = '0;
      w.opcode = OP_ADD;
      w.source_id = $urandom;
      w.target_id = ~w.source_id;
      w.first_x = ax;
      w.first_y = ay;
      w.second_x = bx;
      w.second_y = by;
      w.read_index = 7'($urandom);
      return w;
   endfunction

   // random word: mostly adds with spans of random magnitude, some reads and skips
   function automatic req_type random_word();
      req_type w;
      int      k;
      w = add_word($urandom, $urandom, 0, 0);
      k = $urandom_range(31);
      w.second_x = 32'(w.first_x + ($urandom & ((64'd1 << k) - 1)) - (32'd1 << k) / 2);
      k = $urandom_range(31);
      w.second_y = 32'(w.first_y + ($urandom & ((64'd1 << k) - 1)) - (32'd1 << k) / 2);
      case ($urandom_range(9))
         0: w.target_id = w.source_id;
         1: begin
            w.second_x = $urandom;
            w.second_y = $urandom;
         end
         2, 3: w.opcode = OP_READ;
         default: ;
      endcase
      return w;
   endfunction

   // stimulus
   initial begin
      req_type w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_MAX_DISTANCE;
      csr_write_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset settings
      send_word(add_word(32'h8000_0000, 0, 32'h7fff_ffff, 0));
      send_word(add_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
      send_word(add_word(5, 5, 5, 5));
      send_word(add_word(0, 32'h7fff_ffff, 0, 32'h8000_0000));
      send_word(add_word(0, 0, 3, 4));
      w = add_word(1, 2, 3, 4);
      w.source_id = '1;
      w.target_id = '1;
      send_word(w);
      w.source_id = '1;
      w.target_id = '0;
      send_word(w);
      w.opcode = OP_READ;
      w.read_index = 7'd127;
      send_word(w);
      w.read_index = 7'd99;
      send_word(w);
      w.read_index = 7'd0;
      send_word(w);
      wait_drained();

      // log mode with a zero divisor, then bucket counts beyond the range
      set_mode(33'd1, 8'd0, 1'b1);
      send_word(add_word(0, 0, 100, 0));
      send_word(add_word(0, 0, 0, 0));
      wait_drained();
      set_mode(33'd0, 8'd255, 1'b0);
      send_word(add_word(0, 0, 100, 0));
      w.read_index = 7'd127;
      send_word(w);
      wait_drained();

      // random phases across settings and idling patterns
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_mode(33'd2, 8'd1, 1'b0);
            1: set_mode(33'h1_ffff_ffff, 8'd128, 1'b1);
            2: set_mode(33'd40075100, 8'd100, 1'b0);
            3: set_mode(33'd2, 8'd128, 1'b1);
            4: set_mode(33'd65536, 8'd17, 1'b0);
            5: set_mode(33'd1_000_000, 8'd200, 1'b1);
            6: set_mode(33'h1_ffff_ffff, 8'd128, 1'b0);
            default: set_mode(33'd3_000_000_000, 8'd64, 1'b1);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         for (int n = 0; n < 150; n++) send_word(random_word());
         wait_drained();
      end

      if (errors == 0 && pending == 0) begin
         $display("edge_length_histogram: match");
      end else begin
         $display("edge_length_histogram: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("edge_length_histogram: mismatch");
      $finish;
   end

endmodule

[sim.f]
rtl/elh_pkg.sv
rtl/elh_ram.sv
rtl/elh_sqrt.sv
rtl/elh_log2.sv
rtl/elh_div.sv
rtl/edge_length_histogram.sv
sim/edge_length_histogram_checker.sv
sim/edge_length_histogram_tb.sv
